### sv/mbcpu_pkg.sv
// Shared types, constants and helpers for the microcoded byte CPU tick engine.
// Used by mbcpu_exec and microcoded_byte_cpu_tick; depends on nothing else.
package mbcpu_pkg;

    // Storage geometry.
    localparam int unsigned MEM_DEPTH_DEF = 32768;
    localparam int unsigned MICRO_DEPTH   = 8192;
    localparam int unsigned MICRO_AW      = $clog2(MICRO_DEPTH);

    // Active-low lines of the raw microcode word are flipped on load.
    localparam logic [15:0] ACT_LOW_MASK = 16'hD97F;

    // Control word bit positions (active high).
    localparam int CW_BO   = 0;
    localparam int CW_BI   = 1;
    localparam int CW_AO   = 2;
    localparam int CW_AI   = 3;
    localparam int CW_RO   = 4;
    localparam int CW_RI   = 5;
    localparam int CW_MI   = 6;
    localparam int CW_HI   = 7;
    localparam int CW_EOFI = 8;
    localparam int CW_ES   = 9;
    localparam int CW_EC   = 10;
    localparam int CW_IC   = 11;
    localparam int CW_II   = 12;
    localparam int CW_CEME = 13;
    localparam int CW_CO   = 14;
    localparam int CW_CI   = 15;

    // Bus idle levels when nothing drives it.
    localparam logic [7:0] BUS_IDLE_HI = 8'h7F;
    localparam logic [7:0] BUS_IDLE_LO = 8'hFF;

    // Command codes of an input word.
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_LOAD_MC  = 2'd1,
        CMD_LOAD_MEM = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    // Architectural registers of the CPU.
    typedef struct packed {
        logic [7:0]  acc_a;
        logic [7:0]  acc_b;
        logic [7:0]  opcode;
        logic [2:0]  flags;
        logic [3:0]  step;
        logic [15:0] pc;
        logic [15:0] mar;
    } t_arch;

    // Everything one executed tick produces.
    typedef struct packed {
        t_arch       next;
        logic [7:0]  bus;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_taken;
        logic        wr_en;
        logic [14:0] wr_addr;
    } t_exec_out;

    // Reduces a 15-bit address into the byte memory; depth is at least a quarter
    // of the address range, so two conditional subtracts are enough.
    function automatic logic [14:0] mem_index(input logic [14:0] addr,
                                              input int unsigned depth);
        logic [16:0] q;
        q = {2'b00, addr};
        if (q >= 17'(2 * depth)) begin
            q = q - 17'(2 * depth);
        end
        if (q >= 17'(depth)) begin
            q = q - 17'(depth);
        end
        return q[14:0];
    endfunction

endpackage

### sv/mbcpu_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// A read of the entry written in the same cycle returns the new data.
module mbcpu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with write-first bypass.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mbcpu_exec.sv
// Execution of one CPU tick once its control word and memory byte are known:
// bus drivers, ALU, register latches and the memory or UART write. Uses mbcpu_pkg.
module mbcpu_exec (
    input  logic [15:0]           i_cw,
    input  logic                  i_ic,
    input  mbcpu_pkg::t_arch      i_arch,
    input  logic [7:0]            i_mem_q,
    input  logic                  i_rx_valid,
    input  logic [7:0]            i_rx_byte,
    output mbcpu_pkg::t_exec_out  o_res
);

    logic [7:0]       bop1;
    logic [7:0]       bop2;
    logic [8:0]       sum1;
    logic [8:0]       sum2;
    logic [7:0]       bus1;
    logic             taken;
    mbcpu_pkg::t_arch nx;

    always_comb begin
        // First ALU evaluation on the registers as they stand.
        bop1 = i_cw[mbcpu_pkg::CW_ES] ? ~i_arch.acc_b : i_arch.acc_b;
        sum1 = {1'b0, i_arch.acc_a} + {1'b0, bop1} + {8'd0, i_cw[mbcpu_pkg::CW_EC]};

        // Bus drivers in priority order, last one wins.
        taken = 1'b0;
        bus1  = i_cw[mbcpu_pkg::CW_HI] ? mbcpu_pkg::BUS_IDLE_HI : mbcpu_pkg::BUS_IDLE_LO;
        if (i_cw[mbcpu_pkg::CW_AO]) begin
            bus1 = i_arch.acc_a;
        end
        if (i_cw[mbcpu_pkg::CW_BO]) begin
            bus1 = i_arch.acc_b;
        end
        if (i_cw[mbcpu_pkg::CW_CO]) begin
            bus1 = i_cw[mbcpu_pkg::CW_HI] ? i_arch.pc[15:8] : i_arch.pc[7:0];
        end
        if (i_cw[mbcpu_pkg::CW_EOFI]) begin
            bus1 = sum1[7:0];
        end
        if (i_cw[mbcpu_pkg::CW_RO]) begin
            if (i_arch.mar[15]) begin
                if (i_rx_valid) begin
                    bus1  = i_rx_byte;
                    taken = 1'b1;
                end else begin
                    bus1 = 8'd0;
                end
            end else begin
                bus1 = i_mem_q;
            end
        end

        // Register latches at the rising edge.
        nx = i_arch;
        if (i_cw[mbcpu_pkg::CW_AI]) begin
            nx.acc_a = bus1;
        end
        if (i_cw[mbcpu_pkg::CW_BI]) begin
            nx.acc_b = bus1;
        end
        if (i_cw[mbcpu_pkg::CW_II]) begin
            nx.opcode = bus1;
        end
        if (i_cw[mbcpu_pkg::CW_EOFI]) begin
            nx.flags = {sum1[7], sum1[8], (sum1[7:0] == 8'd0)};
        end
        nx.step = i_ic ? 4'd1 : i_arch.step + 4'd1;
        if (i_cw[mbcpu_pkg::CW_CI]) begin
            nx.pc = i_cw[mbcpu_pkg::CW_HI] ? {bus1, i_arch.pc[7:0]}
                                           : {i_arch.pc[15:8], bus1};
        end else if (i_cw[mbcpu_pkg::CW_CEME]) begin
            nx.pc = i_arch.pc + 16'd1;
        end
        if (i_cw[mbcpu_pkg::CW_MI]) begin
            nx.mar = i_cw[mbcpu_pkg::CW_HI] ? {bus1, i_arch.mar[7:0]}
                                            : {i_arch.mar[15:8], bus1};
        end else if (i_cw[mbcpu_pkg::CW_CEME]) begin
            nx.mar = i_arch.mar + 16'd1;
        end

        // The ALU settles again on the latched accumulators.
        bop2 = i_cw[mbcpu_pkg::CW_ES] ? ~nx.acc_b : nx.acc_b;
        sum2 = {1'b0, nx.acc_a} + {1'b0, bop2} + {8'd0, i_cw[mbcpu_pkg::CW_EC]};

        o_res.next     = nx;
        o_res.bus      = i_cw[mbcpu_pkg::CW_EOFI] ? sum2[7:0] : bus1;
        o_res.rx_taken = taken;
        o_res.wr_addr  = nx.mar[14:0];

        // UART send of nonzero bytes, or a RAM write above the ROM.
        o_res.tx_valid = 1'b0;
        o_res.tx_byte  = 8'd0;
        o_res.wr_en    = 1'b0;
        if (i_cw[mbcpu_pkg::CW_RI]) begin
            if (nx.mar[15]) begin
                if (o_res.bus != 8'd0) begin
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = o_res.bus;
                end
            end else if (nx.mar[14:13] != 2'b00) begin
                o_res.wr_en = 1'b1;
            end
        end
    end

endmodule

### sv/microcoded_byte_cpu_tick.sv
// Top level of the microcoded byte CPU tick engine: sequencer, CPU registers,
// microcode store and byte memory. Uses mbcpu_pkg, mbcpu_ram and mbcpu_exec.
//
// Each input word is a clock tick of the CPU, a no-op or a load of one
// microcode word or memory byte, and gives one output word. A tick reads the
// microcode store in the cycle it is accepted, then the byte memory in S_LOOK,
// or in S_RELOOK when the IC bit of the control word forces a second read,
// and executes and writes back in S_EXEC. A load is written in S_LOAD. S_EXEC
// and S_LOAD also accept the next word as the current one retires, unless the
// output is stalled. The two memory read latencies set the tick rate. The
// memories have no reset; results from entries never written are unspecified.
// A finished word waits in the output register while the next is worked on.
module microcoded_byte_cpu_tick #(
    parameter int unsigned MEM_DEPTH = mbcpu_pkg::MEM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [14:0] i_load_addr,
    input  logic [15:0] i_load_data,
    input  logic        i_rx_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_rx_taken,
    output logic [7:0]  o_bus_value,
    output logic [15:0] o_control_word,
    output logic [15:0] o_pc_value
);

    localparam int unsigned MAW = $clog2(MEM_DEPTH);
    localparam int unsigned CAW = mbcpu_pkg::MICRO_AW;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK   = 5'b00010,
        S_RELOOK = 5'b00100,
        S_EXEC   = 5'b01000,
        S_LOAD   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    mbcpu_pkg::t_arch     r_arch, n_arch;
    mbcpu_pkg::t_exec_out ex;

    logic [1:0]  r_cmd;
    logic [14:0] r_load_addr;
    logic [15:0] r_load_data;
    logic        r_rx_valid;
    logic [7:0]  r_rx_byte;
    logic [15:0] r_cw;
    logic        r_ic;

    logic        r_out_valid;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic        r_rx_taken;
    logic [7:0]  r_bus_value;
    logic [15:0] r_control_word;
    logic [15:0] r_pc_value;

    logic        accept, commit, out_free, in_ready;
    logic        mc_we, mc_re;
    logic [CAW-1:0] mc_waddr, mc_raddr;
    logic [15:0] mc_wdata, mc_q;
    logic        bm_we, bm_re;
    logic [14:0] bm_widx, bm_ridx;
    logic [7:0]  bm_wdata, bm_q;

    // Handshake: the word in the final cycle retires as the next one enters.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = ((r_state == S_EXEC) || (r_state == S_LOAD)) && out_free;
    assign in_ready   = (r_state == S_IDLE) || commit;
    assign o_in_stall = !in_ready;
    assign accept     = i_in_valid && in_ready;

    // Register values that the next tick's lookup sees.
    assign n_arch = (commit && (r_state == S_EXEC)) ? ex.next : r_arch;

    // Microcode store: read at accept and again after IC, written by loads.
    always_comb begin
        mc_re    = 1'b0;
        mc_raddr = {n_arch.flags, n_arch.opcode[5:0], n_arch.step};
        if (accept && (mbcpu_pkg::t_cmd'(i_cmd) == mbcpu_pkg::CMD_TICK)) begin
            mc_re = 1'b1;
        end else if ((r_state == S_LOOK) && mc_q[mbcpu_pkg::CW_IC]) begin
            mc_re    = 1'b1;
            mc_raddr = {r_arch.flags, r_arch.opcode[5:0], 4'd0};
        end
    end

    assign mc_we    = commit && (r_state == S_LOAD)
                      && (mbcpu_pkg::t_cmd'(r_cmd) == mbcpu_pkg::CMD_LOAD_MC);
    assign mc_waddr = r_load_addr[CAW-1:0];
    assign mc_wdata = r_load_data ^ mbcpu_pkg::ACT_LOW_MASK;

    mbcpu_ram #(
        .WIDTH (16),
        .DEPTH (mbcpu_pkg::MICRO_DEPTH)
    ) u_micro (
        .i_clk   (i_clk),
        .i_we    (mc_we),
        .i_waddr (mc_waddr),
        .i_wdata (mc_wdata),
        .i_re    (mc_re),
        .i_raddr (mc_raddr),
        .o_rdata (mc_q)
    );

    // Byte memory: read once the control word is final, written at retire.
    assign bm_re   = ((r_state == S_LOOK) && !mc_q[mbcpu_pkg::CW_IC]) || (r_state == S_RELOOK);
    assign bm_ridx = mbcpu_pkg::mem_index(r_arch.mar[14:0], MEM_DEPTH);

    always_comb begin
        bm_we    = 1'b0;
        bm_widx  = mbcpu_pkg::mem_index(ex.wr_addr, MEM_DEPTH);
        bm_wdata = ex.bus;
        if (commit && (r_state == S_LOAD)) begin
            bm_we    = (mbcpu_pkg::t_cmd'(r_cmd) == mbcpu_pkg::CMD_LOAD_MEM);
            bm_widx  = mbcpu_pkg::mem_index(r_load_addr, MEM_DEPTH);
            bm_wdata = r_load_data[7:0];
        end else if (commit && (r_state == S_EXEC)) begin
            bm_we = ex.wr_en;
        end
    end

    mbcpu_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_bytes (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_widx[MAW-1:0]),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_ridx[MAW-1:0]),
        .o_rdata (bm_q)
    );

    // Tick execution.
    mbcpu_exec u_exec (
        .i_cw       (r_cw),
        .i_ic       (r_ic),
        .i_arch     (r_arch),
        .i_mem_q    (bm_q),
        .i_rx_valid (r_rx_valid),
        .i_rx_byte  (r_rx_byte),
        .o_res      (ex)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_EXEC, S_LOAD: begin
                if (accept) begin
                    n_state = (mbcpu_pkg::t_cmd'(i_cmd) == mbcpu_pkg::CMD_TICK) ? S_LOOK
                                                                                : S_LOAD;
                end else if (commit) begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK: begin
                n_state = mc_q[mbcpu_pkg::CW_IC] ? S_RELOOK : S_EXEC;
            end
            S_RELOOK: begin
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and CPU registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_arch      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_arch  <= n_arch;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured input word and the final control word of the tick.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= i_cmd;
            r_load_addr <= i_load_addr;
            r_load_data <= i_load_data;
            r_rx_valid  <= i_rx_valid;
            r_rx_byte   <= i_rx_byte;
        end
        if (r_state == S_LOOK) begin
            r_cw <= mc_q;
            r_ic <= mc_q[mbcpu_pkg::CW_IC];
        end else if (r_state == S_RELOOK) begin
            r_cw <= mc_q;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            if (r_state == S_EXEC) begin
                r_tx_valid     <= ex.tx_valid;
                r_tx_byte      <= ex.tx_byte;
                r_rx_taken     <= ex.rx_taken;
                r_bus_value    <= ex.bus;
                r_control_word <= r_cw;
                r_pc_value     <= ex.next.pc;
            end else begin
                r_tx_valid     <= 1'b0;
                r_tx_byte      <= 8'd0;
                r_rx_taken     <= 1'b0;
                r_bus_value    <= 8'd0;
                r_control_word <= 16'd0;
                r_pc_value     <= r_arch.pc;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tx_valid     = r_tx_valid;
    assign o_tx_byte      = r_tx_byte;
    assign o_rx_taken     = r_rx_taken;
    assign o_bus_value    = r_bus_value;
    assign o_control_word = r_control_word;
    assign o_pc_value     = r_pc_value;

    // A word is never retired while the previous result is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !commit)
        else $error("result overwritten while output is stalled");

    // An accepted tick always starts with a microcode read.
    a_tick_reads_mc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (mbcpu_pkg::t_cmd'(i_cmd) == mbcpu_pkg::CMD_TICK)) |=> (r_state == S_LOOK))
        else $error("tick accepted without microcode lookup");

    // Only nonzero bytes go to the UART.
    a_tx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tx_valid) |-> (r_tx_byte != 8'd0))
        else $error("zero byte sent to UART");

    // A consumed receive byte needs a memory read in the control word.
    a_rx_needs_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rx_taken) |-> r_control_word[mbcpu_pkg::CW_RO])
        else $error("receive byte taken without RO");

    // A tick never writes into the ROM or UART range of the byte memory.
    a_rom_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_state == S_EXEC) && bm_we)
        |-> (!ex.next.mar[15] && (ex.next.mar[14:13] != 2'b00)))
        else $error("tick wrote protected memory");

endmodule

### verif/microcoded_byte_cpu_tick_test.sv
// Self-checking testbench for microcoded_byte_cpu_tick: a tick-level CPU predictor
// in a scoreboard class checks every output word. Depends on mbcpu_pkg and the RTL.
`timescale 1ns / 1ps

// One input word: a CPU tick, a store load or a no-op.
typedef struct packed {
    mbcpu_pkg::t_cmd cmd;
    logic [14:0]     load_addr;
    logic [15:0]     load_data;
    logic            rx_valid;
    logic [7:0]      rx_byte;
} t_cpu_word;

// One output word.
typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_taken;
    logic [7:0]  bus;
    logic [15:0] control;
    logic [15:0] pc;
} t_tick_result;

// CPU state tracking and output checking.
class cpu_tick_board;
    localparam logic [15:0] RAM_BASE = 16'h2000;
    localparam int UART_BIT = 15;

    logic [15:0] micro_words [mbcpu_pkg::MICRO_DEPTH];
    bit          micro_known [mbcpu_pkg::MICRO_DEPTH];
    logic [7:0]  ram_bytes [mbcpu_pkg::MEM_DEPTH_DEF];
    bit          ram_known [mbcpu_pkg::MEM_DEPTH_DEF];

    logic [7:0]  acc_a, acc_b, opcode;
    logic [2:0]  flags;
    logic [3:0]  step;
    logic [15:0] pc, mar;

    t_tick_result due_results[$];
    int fail_count;

    function new();
        acc_a = '0;
        acc_b = '0;
        opcode = '0;
        flags = '0;
        step = '0;
        pc = '0;
        mar = '0;
        fail_count = 0;
    endfunction

    function logic [12:0] micro_index(input logic [3:0] at_step);
        return {flags, opcode[5:0], at_step};
    endfunction

    // Adder with optional inverted B and carry in; f is {negative, carry, zero}.
    function logic [7:0] alu_out(input logic [15:0] control, output logic [2:0] f);
        logic [7:0] b;
        logic [8:0] sum;
        b = control[mbcpu_pkg::CW_ES] ? ~acc_b : acc_b;
        sum = {1'b0, acc_a} + {1'b0, b} + {8'd0, control[mbcpu_pkg::CW_EC]};
        f = {sum[7], sum[8], sum[7:0] == 8'd0};
        return sum[7:0];
    endfunction

    function logic [15:0] load_half(input logic [15:0] r, input logic [15:0] control,
                                    input logic [7:0] bus);
        return control[mbcpu_pkg::CW_HI] ? {bus, r[7:0]} : {r[15:8], bus};
    endfunction

    // Tells which store entry a tick issued now would read before it is written.
    function mbcpu_pkg::t_cmd missing_entry(output logic [14:0] at);
        logic [12:0] idx;
        logic [15:0] control;
        at = '0;
        idx = micro_index(step);
        if (!micro_known[idx]) begin
            at = {2'b00, idx};
            return mbcpu_pkg::CMD_LOAD_MC;
        end
        control = micro_words[idx];
        if (control[mbcpu_pkg::CW_IC]) begin
            idx = micro_index(4'd0);
            if (!micro_known[idx]) begin
                at = {2'b00, idx};
                return mbcpu_pkg::CMD_LOAD_MC;
            end
            control = micro_words[idx];
        end
        if (control[mbcpu_pkg::CW_RO] && !mar[UART_BIT] && !ram_known[mar[14:0]]) begin
            at = mar[14:0];
            return mbcpu_pkg::CMD_LOAD_MEM;
        end
        return mbcpu_pkg::CMD_TICK;
    endfunction

    // Applies one input word to the CPU state and returns the output it gives.
    function t_tick_result run_word(input t_cpu_word w);
        t_tick_result r;
        logic [15:0] control;
        logic [7:0] bus, res;
        logic [2:0] f;
        r = '0;
        case (w.cmd)
            mbcpu_pkg::CMD_LOAD_MC: begin
                micro_words[w.load_addr % mbcpu_pkg::MICRO_DEPTH] =
                    w.load_data ^ mbcpu_pkg::ACT_LOW_MASK;
                micro_known[w.load_addr % mbcpu_pkg::MICRO_DEPTH] = 1'b1;
            end
            mbcpu_pkg::CMD_LOAD_MEM: begin
                ram_bytes[w.load_addr % mbcpu_pkg::MEM_DEPTH_DEF] = w.load_data[7:0];
                ram_known[w.load_addr % mbcpu_pkg::MEM_DEPTH_DEF] = 1'b1;
            end
            default: ;
        endcase
        if (w.cmd != mbcpu_pkg::CMD_TICK) begin
            r.pc = pc;
            return r;
        end

        // Control lookup, repeated from step zero when IC is set.
        control = micro_words[micro_index(step)];
        if (control[mbcpu_pkg::CW_IC]) begin
            step = 4'd0;
            control = micro_words[micro_index(4'd0)];
        end

        // Bus drivers in priority order.
        bus = control[mbcpu_pkg::CW_HI] ? mbcpu_pkg::BUS_IDLE_HI : mbcpu_pkg::BUS_IDLE_LO;
        if (control[mbcpu_pkg::CW_AO]) bus = acc_a;
        if (control[mbcpu_pkg::CW_BO]) bus = acc_b;
        if (control[mbcpu_pkg::CW_CO]) bus = control[mbcpu_pkg::CW_HI] ? pc[15:8] : pc[7:0];
        res = alu_out(control, f);
        if (control[mbcpu_pkg::CW_EOFI]) bus = res;
        if (control[mbcpu_pkg::CW_RO]) begin
            if (mar[UART_BIT]) begin
                if (w.rx_valid) begin
                    bus = w.rx_byte;
                    r.rx_taken = 1'b1;
                end else begin
                    bus = 8'd0;
                end
            end else begin
                bus = ram_bytes[mar % mbcpu_pkg::MEM_DEPTH_DEF];
            end
        end

        // Register latches; flags take the first ALU pass.
        if (control[mbcpu_pkg::CW_AI]) acc_a = bus;
        if (control[mbcpu_pkg::CW_BI]) acc_b = bus;
        if (control[mbcpu_pkg::CW_II]) opcode = bus;
        if (control[mbcpu_pkg::CW_EOFI]) flags = f;
        step = step + 4'd1;
        if (control[mbcpu_pkg::CW_CI]) pc = load_half(pc, control, bus);
        else if (control[mbcpu_pkg::CW_CEME]) pc = pc + 16'd1;
        if (control[mbcpu_pkg::CW_MI]) mar = load_half(mar, control, bus);
        else if (control[mbcpu_pkg::CW_CEME]) mar = mar + 16'd1;

        // The ALU settles again on the new registers before the write.
        res = alu_out(control, f);
        if (control[mbcpu_pkg::CW_EOFI]) bus = res;
        if (control[mbcpu_pkg::CW_RI]) begin
            if (mar[UART_BIT]) begin
                if (bus != 8'd0) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = bus;
                end
            end else if (mar >= RAM_BASE) begin
                ram_bytes[mar % mbcpu_pkg::MEM_DEPTH_DEF] = bus;
                ram_known[mar % mbcpu_pkg::MEM_DEPTH_DEF] = 1'b1;
            end
        end

        r.bus = bus;
        r.control = control;
        r.pc = pc;
        return r;
    endfunction

    function void note_word(input t_cpu_word w);
        due_results.push_back(run_word(w));
    endfunction

    task report(input string what);
        $display("MISMATCH: %s", what);
        fail_count++;
    endtask

    task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task check_word(input t_tick_result got);
        t_tick_result want;
        if (due_results.size() == 0) begin
            report("output word arrived with nothing expected");
            return;
        end
        want = due_results.pop_front();
        compare_field("tx_valid", 16'(got.tx_valid), 16'(want.tx_valid));
        compare_field("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
        compare_field("rx_taken", 16'(got.rx_taken), 16'(want.rx_taken));
        compare_field("bus_value", 16'(got.bus), 16'(want.bus));
        compare_field("control_word", got.control, want.control);
        compare_field("pc_value", got.pc, want.pc);
    endtask
endclass

module microcoded_byte_cpu_tick_test;

    localparam int ITEM_TARGET  = 1600;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = mbcpu_pkg::CMD_NOP;
    logic [14:0] i_load_addr = '0;
    logic [15:0] i_load_data = '0;
    logic        i_rx_valid = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_rx_taken;
    logic [7:0]  o_bus_value;
    logic [15:0] o_control_word;
    logic [15:0] o_pc_value;

    cpu_tick_board board;
    int           burst_left = 0;
    int           words_sent = 0;
    int           cycle_count = 0;
    int           stall_style = 0;
    int           stall_span = 0;
    t_tick_result seen_word;

    microcoded_byte_cpu_tick DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_load_addr    (i_load_addr),
        .i_load_data    (i_load_data),
        .i_rx_valid     (i_rx_valid),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_rx_taken     (o_rx_taken),
        .o_bus_value    (o_bus_value),
        .o_control_word (o_control_word),
        .o_pc_value     (o_pc_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Random control word with IC mostly clear so that steps advance.
    function logic [15:0] fresh_control();
        logic [15:0] control;
        control = 16'($urandom);
        if ($urandom_range(3) != 0) control[mbcpu_pkg::CW_IC] = 1'b0;
        return control;
    endfunction

    // Presents one word, in bursts with random gaps, and holds it until accepted.
    task send_word(input t_cpu_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_cmd       <= w.cmd;
        i_load_addr <= w.load_addr;
        i_load_data <= w.load_data;
        i_rx_valid  <= w.rx_valid;
        i_rx_byte   <= w.rx_byte;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_word(w);
        words_sent++;
    endtask

    task send_load(input mbcpu_pkg::t_cmd kind, input logic [14:0] addr,
                   input logic [15:0] data);
        t_cpu_word w;
        w.cmd = kind;
        w.load_addr = addr;
        w.load_data = data;
        w.rx_valid = 1'($urandom);
        w.rx_byte = 8'($urandom);
        send_word(w);
    endtask

    // Fills any store entry the tick would read, then sends the tick.
    task send_tick(input logic rxv, input logic [7:0] rxb);
        t_cpu_word w;
        mbcpu_pkg::t_cmd need;
        logic [14:0] at;
        need = board.missing_entry(at);
        while (need != mbcpu_pkg::CMD_TICK) begin
            if (need == mbcpu_pkg::CMD_LOAD_MC)
                send_load(mbcpu_pkg::CMD_LOAD_MC, {2'($urandom), at[12:0]},
                          fresh_control() ^ mbcpu_pkg::ACT_LOW_MASK);
            else
                send_load(mbcpu_pkg::CMD_LOAD_MEM, at, 16'($urandom));
            need = board.missing_entry(at);
        end
        w.cmd = mbcpu_pkg::CMD_TICK;
        w.load_addr = 15'($urandom);
        w.load_data = 16'($urandom);
        w.rx_valid = rxv;
        w.rx_byte = rxb;
        send_word(w);
    endtask

    // Places a chosen control word at the entry the next tick looks up, then ticks.
    task tick_with(input logic [15:0] control, input logic rxv, input logic [7:0] rxb);
        send_load(mbcpu_pkg::CMD_LOAD_MC, {2'($urandom), board.micro_index(board.step)},
                  control ^ mbcpu_pkg::ACT_LOW_MASK);
        send_tick(rxv, rxb);
    endtask

    // Output side: check accepted words and stall in changing styles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_word.tx_valid = o_tx_valid;
            seen_word.tx_byte  = o_tx_byte;
            seen_word.rx_taken = o_rx_taken;
            seen_word.bus      = o_bus_value;
            seen_word.control  = o_control_word;
            seen_word.pc       = o_pc_value;
            board.check_word(seen_word);
        end
        if (stall_span == 0) begin
            stall_style = $urandom_range(2);
            stall_span = $urandom_range(8, 64);
        end
        stall_span--;
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(2) == 0);
            default: i_out_stall <= ((stall_span % 7) < 3);
        endcase
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int pick;
        t_cpu_word w;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: no-op with all-ones payload, then hand-picked control words.
        w = '{cmd: mbcpu_pkg::CMD_NOP, load_addr: 15'h7FFF, load_data: 16'hFFFF,
              rx_valid: 1'b1, rx_byte: 8'hFF};
        send_word(w);
        // Write to the ROM area is ignored; bus idles at 0x7F under HI.
        tick_with(16'((1 << mbcpu_pkg::CW_HI) | (1 << mbcpu_pkg::CW_RI)), 1'b0, 8'h00);
        tick_with(16'((1 << mbcpu_pkg::CW_HI) | (1 << mbcpu_pkg::CW_MI)), 1'b0, 8'h00);
        tick_with(16'(1 << mbcpu_pkg::CW_RI), 1'b0, 8'h00);
        tick_with(16'((1 << mbcpu_pkg::CW_RO) | (1 << mbcpu_pkg::CW_AI)), 1'b0, 8'h00);
        // Point the address register into the UART range.
        tick_with(16'((1 << mbcpu_pkg::CW_HI) | (1 << mbcpu_pkg::CW_MI)
                      | (1 << mbcpu_pkg::CW_AO)), 1'b0, 8'h00);
        // UART read with nothing offered gives 0, and that zero write is dropped.
        tick_with(16'((1 << mbcpu_pkg::CW_RO) | (1 << mbcpu_pkg::CW_RI)
                      | (1 << mbcpu_pkg::CW_BI)), 1'b0, 8'h5A);
        tick_with(16'((1 << mbcpu_pkg::CW_RO) | (1 << mbcpu_pkg::CW_BI)), 1'b1, 8'h80);
        // ALU result differs after the A latch; flags keep the first pass.
        tick_with(16'((1 << mbcpu_pkg::CW_EOFI) | (1 << mbcpu_pkg::CW_AI)), 1'b0, 8'h00);
        tick_with(16'((1 << mbcpu_pkg::CW_EOFI) | (1 << mbcpu_pkg::CW_ES)
                      | (1 << mbcpu_pkg::CW_EC) | (1 << mbcpu_pkg::CW_RI)),
                  1'b0, 8'h00);
        tick_with(16'((1 << mbcpu_pkg::CW_CEME) | (1 << mbcpu_pkg::CW_CO)
                      | (1 << mbcpu_pkg::CW_AI)), 1'b0, 8'h00);
        tick_with(16'((1 << mbcpu_pkg::CW_CI) | (1 << mbcpu_pkg::CW_HI)
                      | (1 << mbcpu_pkg::CW_BO)), 1'b0, 8'h00);
        tick_with(16'hFFFF, 1'b1, 8'h00);

        // Random mix, mostly ticks through randomly filled microcode.
        while (words_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_tick(1'($urandom), 8'($urandom));
            end else if (pick < 75) begin
                tick_with(fresh_control(), 1'($urandom), 8'($urandom));
            end else if (pick < 83) begin
                send_load(mbcpu_pkg::CMD_LOAD_MC, 15'($urandom),
                          fresh_control() ^ mbcpu_pkg::ACT_LOW_MASK);
            end else if (pick < 93) begin
                send_load(mbcpu_pkg::CMD_LOAD_MEM, 15'($urandom), 16'($urandom));
            end else begin
                send_load(mbcpu_pkg::CMD_NOP, 15'($urandom), 16'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        while (board.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
